// ===== src/salc_pkg.sv =====
// Shared constants and codes for the set-associative LRU cache model.
// No dependencies; salc_ifs.sv and the top level import this package.
`default_nettype none

package salc_pkg;

   // Parameter defaults for the top level
   localparam int DEF_MAX_SETS = 1024;
   localparam int DEF_MAX_WAYS = 8;

   // Field widths
   localparam int ACTION_W   = 2;
   localparam int ADDR_W     = 32;
   localparam int OUTCOME_W  = 2;
   localparam int TOTAL_W    = 32;
   localparam int TAG_W      = 30;  // address minus one set bit and one offset bit
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Configuration register widths and reset values
   localparam int SET_BITS_W   = 4;
   localparam int WAY_COUNT_W  = 4;
   localparam int BLOCK_BITS_W = 5;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 4'd1;
   localparam logic [WAY_COUNT_W-1:0]  WAY_COUNT_RST  = 4'd1;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;

   // Register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] REG_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAY_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

   // Access kinds
   localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd2;

   // Outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

endpackage

`default_nettype wire

// ===== src/salc_ifs.sv =====
// Valid/ready channel interfaces: access request, result, register write.
// Depends on salc_pkg for field widths.
`default_nettype none

interface salc_req_if import salc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   mem_address;

   modport source (output valid, output action, output mem_address, input ready);
   modport sink   (input valid, input action, input mem_address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 second_hit;
   logic [TOTAL_W-1:0]   total_hits;
   logic [TOTAL_W-1:0]   total_misses;
   logic [TOTAL_W-1:0]   total_evictions;

   modport source (output valid, output outcome, output second_hit, output total_hits,
                   output total_misses, output total_evictions, input ready);
   modport sink   (input valid, input outcome, input second_hit, input total_hits,
                   input total_misses, input total_evictions, output ready);
endinterface

interface salc_csr_if import salc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== src/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module salc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_model.sv =====
// Top level: set-associative cache hit/miss model with exact LRU replacement.
// Depends on salc_pkg, the interfaces in salc_ifs.sv and salc_ram.
//
// Channel   Port     Dir  Beat contents
// request   req_ch   in   action, mem_address
// result    rsp_ch   out  outcome, second_hit, total_hits/misses/evictions
// config    csr_ch   in   reg_index (0 set_bits, 1 way_count, 2 block_bits), wr_data
//
// The block takes no new request until the current one has passed its split,
// read, scan and write steps; the tag compare is one shared comparator stepped
// over the effective way count of the set, one way per cycle.
// After reset a clearing pass writes every set row of the valid/rank RAM while
// req_ch.ready stays low; csr_ch is always ready.
// A result waits in the output register; the block accepts the next request
// meanwhile and stalls only in its write step if that register is still full.
`default_nettype none

module set_assoc_lru_cache_model import salc_pkg::*; #(
   parameter int MAX_SETS = DEF_MAX_SETS,
   parameter int MAX_WAYS = DEF_MAX_WAYS
) (
   input  wire logic clock,
   input  wire logic reset,
   salc_req_if.sink   req_ch,
   salc_rsp_if.source rsp_ch,
   salc_csr_if.sink   csr_ch
);

   // ---------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------
   localparam int SET_W   = $clog2(MAX_SETS);                    // set row address
   localparam int SMAX    = $clog2(MAX_SETS + 1) - 1;            // largest usable set_bits
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1; // way index
   localparam int WCNT_W  = $clog2(MAX_WAYS + 1);                // way count
   localparam int RANK_W  = WAY_W;                               // age rank, 0 = newest
   localparam int META_W  = RANK_W + 1;                          // {valid, rank} per way
   localparam int MROW_W  = MAX_WAYS * META_W;
   localparam int TROW_W  = MAX_WAYS * TAG_W;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SPLIT = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;

   // ---------------------------------------------------------------
   // Configuration registers; the channel never stalls
   // ---------------------------------------------------------------
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [WAY_COUNT_W-1:0]  way_count_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         way_count_ff  <= WAY_COUNT_RST;
         block_bits_ff <= BLOCK_BITS_RST;
      end else if (csr_ch.valid) begin
         // drop writes to indexes beyond the register list
         unique case (csr_ch.reg_index)
            REG_SET_BITS:   set_bits_ff   <= csr_ch.wr_data[SET_BITS_W-1:0];
            REG_WAY_COUNT:  way_count_ff  <= csr_ch.wr_data[WAY_COUNT_W-1:0];
            REG_BLOCK_BITS: block_bits_ff <= csr_ch.wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and item registers
   // ---------------------------------------------------------------
   logic [2:0]          state_ff, state_in;
   logic [SET_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [ACTION_W-1:0] action_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [WCNT_W-1:0]   ways_ff;
   logic [WAY_W-1:0]    scan_idx_ff, scan_idx_in;

   // scan results
   logic                hit_found_ff, inv_found_ff;
   logic [WAY_W-1:0]    hit_way_ff, inv_way_ff, vict_way_ff;
   logic [RANK_W-1:0]   hit_rank_ff, vict_rank_ff;

   // totals and result register
   logic [TOTAL_W-1:0]   hit_total_ff, miss_total_ff, evict_total_ff;
   logic [TOTAL_W-1:0]   hit_total_in, miss_total_in, evict_total_in;
   logic                 rsp_valid_ff;
   logic [OUTCOME_W-1:0] rsp_outcome_ff;
   logic                 rsp_second_ff;

   logic req_fire;
   logic write_go;      // write step proceeds: output register free or draining
   logic scan_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign write_go     = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_ch.ready);
   assign scan_last    = ((WCNT_W'(scan_idx_ff) + WCNT_W'(1)) == ways_ff);

   // ---------------------------------------------------------------
   // Address split: saturate config, shift out offset, mask set index
   // ---------------------------------------------------------------
   logic [4:0]        s_eff;
   logic [4:0]        b_eff;
   logic [5:0]        shamt;
   logic [WCNT_W-1:0] ways_eff;
   logic [ADDR_W-1:0] set_mask;
   logic [SET_W-1:0]  set_in;
   logic [TAG_W-1:0]  tag_in;

   always_comb begin
      priority if (set_bits_ff == '0) begin
         s_eff = 5'd1;
      end else if ({1'b0, set_bits_ff} > 5'(SMAX)) begin
         s_eff = 5'(SMAX);
      end else begin
         s_eff = {1'b0, set_bits_ff};
      end

      b_eff = (block_bits_ff == '0) ? 5'd1 : block_bits_ff;

      priority if (way_count_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (5'(way_count_ff) > 5'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(way_count_ff);
      end

      shamt    = 6'(s_eff) + 6'(b_eff);
      set_mask = ~({ADDR_W{1'b1}} << s_eff);
      set_in   = SET_W'((addr_ff >> b_eff) & set_mask);
      tag_in   = TAG_W'(addr_ff >> shamt);
   end

   // ---------------------------------------------------------------
   // Set row RAMs: {valid, rank} per way (cleared), tags (never cleared)
   // ---------------------------------------------------------------
   logic              meta_we;
   logic [SET_W-1:0]  meta_waddr;
   logic [MROW_W-1:0] meta_wdata, meta_rdata, meta_row_in;
   logic              tag_we;
   logic [TROW_W-1:0] tag_rdata, tag_row_in;

   assign meta_we    = (state_ff == ST_CLEAR) || write_go;
   assign meta_waddr = (state_ff == ST_CLEAR) ? clr_idx_ff : set_ff;
   assign meta_wdata = (state_ff == ST_CLEAR) ? '0 : meta_row_in;
   assign tag_we     = write_go && !hit_found_ff;

   salc_ram #(.WIDTH(MROW_W), .DEPTH(MAX_SETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (set_ff),
      .rd_data (meta_rdata)
   );

   salc_ram #(.WIDTH(TROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_ff),
      .wr_data (tag_row_in),
      .rd_addr (set_ff),
      .rd_data (tag_rdata)
   );

   // Unpack the set row into per-way views
   logic              way_valid [MAX_WAYS];
   logic [RANK_W-1:0] way_rank  [MAX_WAYS];
   logic [TAG_W-1:0]  way_tag   [MAX_WAYS];

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_valid[i] = meta_rdata[i*META_W + RANK_W];
         way_rank[i]  = meta_rdata[i*META_W +: RANK_W];
         way_tag[i]   = tag_rdata[i*TAG_W +: TAG_W];
      end
   end

   // ---------------------------------------------------------------
   // Shared scan unit: one way per cycle
   // ---------------------------------------------------------------
   logic              cur_valid;
   logic [RANK_W-1:0] cur_rank;
   logic              cur_match;

   assign cur_valid = way_valid[scan_idx_ff];
   assign cur_rank  = way_rank[scan_idx_ff];
   assign cur_match = cur_valid && (way_tag[scan_idx_ff] == tag_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         hit_found_ff <= 1'b0;
         inv_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         // keep the first match and the first free way
         if (cur_match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_way_ff   <= scan_idx_ff;
            hit_rank_ff  <= cur_rank;
         end
         if (!cur_valid && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_way_ff   <= scan_idx_ff;
         end
         // oldest way, lowest index on ties
         if (scan_idx_ff == '0 || cur_rank > vict_rank_ff) begin
            vict_way_ff  <= scan_idx_ff;
            vict_rank_ff <= cur_rank;
         end
      end
   end

   // ---------------------------------------------------------------
   // Write step: pick the way, age the others, build new rows
   // ---------------------------------------------------------------
   logic [WAY_W-1:0]     w_sel;
   logic                 limit_all;
   logic [RANK_W-1:0]    limit_rank;
   logic [OUTCOME_W-1:0] outcome_in;
   logic                 second_in;
   logic [1:0]           hit_inc;

   always_comb begin
      priority if (hit_found_ff) begin
         w_sel      = hit_way_ff;
         limit_all  = 1'b0;
         limit_rank = hit_rank_ff;
         outcome_in = OUT_HIT;
      end else if (inv_found_ff) begin
         w_sel      = inv_way_ff;
         limit_all  = 1'b1;
         limit_rank = vict_rank_ff;
         outcome_in = OUT_MISS;
      end else begin
         w_sel      = vict_way_ff;
         limit_all  = 1'b0;
         limit_rank = vict_rank_ff;
         outcome_in = OUT_EVICT;
      end

      meta_row_in = meta_rdata;
      tag_row_in  = tag_rdata;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WCNT_W'(i) < ways_ff) begin
            if (WAY_W'(i) == w_sel) begin
               meta_row_in[i*META_W +: META_W] = {1'b1, {RANK_W{1'b0}}};
               tag_row_in[i*TAG_W +: TAG_W]    = tag_ff;
            end else if (way_valid[i] && (limit_all || way_rank[i] < limit_rank) &&
                         way_rank[i] < RANK_MAX) begin
               meta_row_in[i*META_W +: RANK_W] = way_rank[i] + RANK_W'(1);
            end
         end
      end

      // a modify's second access lands on the line just touched: always a hit,
      // and its promotion leaves every rank as it is
      second_in = (action_ff == ACT_MODIFY);
      hit_inc   = 2'(hit_found_ff) + 2'(second_in);

      hit_total_in   = hit_total_ff + TOTAL_W'(hit_inc);
      miss_total_in  = hit_found_ff ? miss_total_ff : miss_total_ff + TOTAL_W'(1);
      evict_total_in = (outcome_in == OUT_EVICT) ? evict_total_ff + TOTAL_W'(1)
                                                 : evict_total_ff;
   end

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      clr_idx_in  = clr_idx_ff;
      scan_idx_in = scan_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + SET_W'(1);
            if (clr_idx_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            scan_idx_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_WRITE;
            end else begin
               scan_idx_in = scan_idx_ff + WAY_W'(1);
            end
         end
         ST_WRITE: begin
            if (write_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
      scan_idx_ff <= scan_idx_in;
   end

   // Capture the beat, then the split address and effective way count
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_ch.action;
         addr_ff   <= req_ch.mem_address;
      end
      if (state_ff == ST_SPLIT) begin
         set_ff  <= set_in;
         tag_ff  <= tag_in;
         ways_ff <= ways_eff;
      end
   end

   // Totals and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (write_go) begin
            hit_total_ff   <= hit_total_in;
            miss_total_ff  <= miss_total_in;
            evict_total_ff <= evict_total_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (write_go) begin
         rsp_outcome_ff <= outcome_in;
         rsp_second_ff  <= second_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.outcome         = rsp_outcome_ff;
   assign rsp_ch.second_hit      = rsp_second_ff;
   assign rsp_ch.total_hits      = hit_total_ff;
   assign rsp_ch.total_misses    = miss_total_ff;
   assign rsp_ch.total_evictions = evict_total_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // the scan never steps past the ways in use
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (WCNT_W'(scan_idx_ff) < ways_ff))
      else $error("scan index beyond way count");

   // a completed write step always leaves a result waiting
   a_write_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      write_go |=> rsp_valid_ff)
      else $error("write step without result");

   // a miss adds exactly one to the miss total
   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (write_go && !hit_found_ff) |=>
         (miss_total_ff == $past(miss_total_ff) + TOTAL_W'(1)))
      else $error("miss total not advanced");

   // eviction only when no way was free and nothing matched
   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (write_go && (outcome_in == OUT_EVICT)) |-> (!hit_found_ff && !inv_found_ff))
      else $error("eviction with free or matching way");

endmodule

`default_nettype wire
